@@ rtl/core/brle_pkg.sv @@
// brle_pkg: shared types and constants of the block row run-length encoder.
// Register map codes, reset values, result beat and queue status types.
// No dependencies.
`timescale 1ns / 1ps

package brle_pkg;

	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;
	localparam int FIELD_BITS  = 16;
	localparam int LABEL_BITS  = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_ROW_LENGTH   = 2'd0;
	localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
	localparam logic [1:0] REG_PARENT_WIDTH = 2'd2;

	localparam logic [FIELD_BITS-1:0] RST_ROW_LENGTH   = 16'd64;
	localparam logic [FIELD_BITS-1:0] RST_ROW_COUNT    = 16'd64;
	localparam logic [FIELD_BITS-1:0] RST_PARENT_WIDTH = 16'd8;

	// room for a full two-beat push regardless of this cycle's pop
	localparam logic [QCNT_BITS-1:0] QCNT_ROOM = 3'd2;

	typedef struct packed {
		logic [FIELD_BITS-1:0] row_length;
		logic [FIELD_BITS-1:0] row_count;
		logic [FIELD_BITS-1:0] parent_width;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] x;
		logic [FIELD_BITS-1:0] y;
		logic [FIELD_BITS-1:0] z;
		logic [FIELD_BITS-1:0] length;
		logic [LABEL_BITS-1:0] label;
		logic                  last;
	} run_t;

	typedef struct packed {
		logic a_valid;
		logic b_valid;
		run_t a;
		run_t b;
	} push_t;

	typedef struct packed {
		logic [QCNT_BITS-1:0] count;
		logic                 room;
	} queue_stat_t;

endpackage

@@ rtl/core/block_row_run_length_encoder.sv @@
// block_row_run_length_encoder: one label beat a cycle in, up to two run beats out per label.
// Path from label acceptance to the first run beat: input register, then result queue.
// Throughput: 1 label per cycle; a label that closes two runs yields two run beats,
// absorbed by the four-beat result queue, which stalls input when fewer than two slots are free.
// Reset (arst_n, asynchronous, active low): no run open, position and queue cleared,
// registers back to 64 / 64 / 8. Depends on brle_pkg, brle_regs, brle_step, brle_queue.
`timescale 1ns / 1ps

module block_row_run_length_encoder
	import brle_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_BITS-1:0]  paddr,
	input  logic [DATA_BITS-1:0]  pwdata,
	output logic [DATA_BITS-1:0]  prdata,
	output logic                  pready,
	input  logic                  label_valid,
	output logic                  label_ready,
	input  logic [LABEL_BITS-1:0] label,
	output logic                  run_valid,
	input  logic                  run_ready,
	output logic [FIELD_BITS-1:0] run_x,
	output logic [FIELD_BITS-1:0] run_y,
	output logic [FIELD_BITS-1:0] run_z,
	output logic [FIELD_BITS-1:0] run_length,
	output logic [LABEL_BITS-1:0] run_label,
	output logic                  last_of_item
);

	cfg_t        cfg;
	push_t       push;
	run_t        run;
	queue_stat_t stat;

	brle_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	brle_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.label_valid (label_valid),
		.label_ready (label_ready),
		.label       (label),
		.cfg         (cfg),
		.room        (stat.room),
		.push        (push)
	);

	brle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run       (run),
		.stat      (stat)
	);

	assign run_x        = run.x;
	assign run_y        = run.y;
	assign run_z        = run.z;
	assign run_length   = run.length;
	assign run_label    = run.label;
	assign last_of_item = run.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.a_valid |-> stat.room)
		else $error("push without room for two beats");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.b_valid |-> (push.a_valid && !push.a.last && push.b.last))
		else $error("second beat without first, or last flag misplaced");

	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.count == '0 && !push.a_valid) |=> !run_valid)
		else $error("run beat appeared from an empty queue");

endmodule

@@ rtl/core/brle_regs.sv @@
// brle_regs: APB-style configuration registers (row_length, row_count, parent_width).
// Depends on brle_pkg.
`timescale 1ns / 1ps

module brle_regs
	import brle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_length   <= RST_ROW_LENGTH;
			cfg_q.row_count    <= RST_ROW_COUNT;
			cfg_q.parent_width <= RST_PARENT_WIDTH;
		end else if (wr_en) begin
			unique case (idx)
				REG_ROW_LENGTH:   cfg_q.row_length   <= pwdata[FIELD_BITS-1:0];
				REG_ROW_COUNT:    cfg_q.row_count    <= pwdata[FIELD_BITS-1:0];
				REG_PARENT_WIDTH: cfg_q.parent_width <= pwdata[FIELD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROW_LENGTH:   prdata = DATA_BITS'(cfg_q.row_length);
			REG_ROW_COUNT:    prdata = DATA_BITS'(cfg_q.row_count);
			REG_PARENT_WIDTH: prdata = DATA_BITS'(cfg_q.parent_width);
			default:          prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/brle_step.sv @@
// brle_step: input register, scan position and open-run state, run cut logic.
// Produces up to two result beats per label. Depends on brle_pkg.
`timescale 1ns / 1ps

module brle_step
	import brle_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  label_valid,
	output logic                  label_ready,
	input  logic [LABEL_BITS-1:0] label,
	input  cfg_t                  cfg,
	input  logic                  room,
	output push_t                 push
);

	logic                  valid_s1;
	logic [LABEL_BITS-1:0] label_s1;

	logic                  open_q;
	logic [LABEL_BITS-1:0] open_label_q;
	logic [FIELD_BITS-1:0] open_start_q;
	logic [FIELD_BITS-1:0] open_length_q;
	logic [FIELD_BITS-1:0] cur_x_q;
	logic [FIELD_BITS-1:0] cur_y_q;
	logic [COORD_BITS-1:0] cur_z_q;
	logic [FIELD_BITS-1:0] phase_q;

	logic                  advance;
	logic [FIELD_BITS-1:0] rl, rc, pw;
	logic                  cut, fresh, row_end, slice_end, phase_wrap;
	logic [FIELD_BITS-1:0] n_start, n_length;
	logic [31:0]           z_ext;
	logic [FIELD_BITS-1:0] z16;
	run_t                  r0, r1;

	assign advance     = valid_s1 & room;
	assign label_ready = ~valid_s1 | advance;

	// zero in a register acts as one
	assign rl = (cfg.row_length   == '0) ? FIELD_BITS'(1) : cfg.row_length;
	assign rc = (cfg.row_count    == '0) ? FIELD_BITS'(1) : cfg.row_count;
	assign pw = (cfg.parent_width == '0) ? FIELD_BITS'(1) : cfg.parent_width;

	assign cut        = open_q & ((label_s1 != open_label_q) | (phase_q == '0));
	assign fresh      = ~open_q | cut;
	assign n_start    = fresh ? cur_x_q : open_start_q;
	assign n_length   = fresh ? FIELD_BITS'(1) : open_length_q + FIELD_BITS'(1);
	assign row_end    = ({1'b0, cur_x_q} + 17'd1) >= {1'b0, rl};
	assign slice_end  = ({1'b0, cur_y_q} + 17'd1) >= {1'b0, rc};
	assign phase_wrap = ({1'b0, phase_q} + 17'd1) >= {1'b0, pw};

	assign z_ext = 32'(cur_z_q);
	assign z16   = z_ext[FIELD_BITS-1:0];

	// run cut off by a new label or a parent boundary; last unless the row ends too
	always_comb begin
		r0.x      = open_start_q;
		r0.y      = cur_y_q;
		r0.z      = z16;
		r0.length = open_length_q;
		r0.label  = open_label_q;
		r0.last   = ~row_end;
		r1.x      = n_start;
		r1.y      = cur_y_q;
		r1.z      = z16;
		r1.length = n_length;
		r1.label  = label_s1;
		r1.last   = 1'b1;
	end

	always_comb begin
		push.a_valid = advance & (cut | row_end);
		push.b_valid = advance & cut & row_end;
		push.a       = cut ? r0 : r1;
		push.b       = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (label_ready) begin
			valid_s1 <= label_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (label_ready && label_valid) begin
			label_s1 <= label;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q        <= 1'b0;
			open_label_q  <= '0;
			open_start_q  <= '0;
			open_length_q <= '0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			cur_z_q       <= '0;
			phase_q       <= '0;
		end else if (advance) begin
			open_q        <= ~row_end;
			open_label_q  <= label_s1;
			open_start_q  <= n_start;
			open_length_q <= n_length;
			if (row_end) begin
				cur_x_q <= '0;
				phase_q <= '0;
				if (slice_end) begin
					cur_y_q <= '0;
					cur_z_q <= cur_z_q + COORD_BITS'(1);
				end else begin
					cur_y_q <= cur_y_q + FIELD_BITS'(1);
				end
			end else begin
				cur_x_q <= cur_x_q + FIELD_BITS'(1);
				phase_q <= phase_wrap ? '0 : phase_q + FIELD_BITS'(1);
			end
		end
	end

endmodule

@@ rtl/core/brle_queue.sv @@
// brle_queue: four-beat result queue, takes up to two beats a cycle, issues one while run_ready is high.
// Depends on brle_pkg.
`timescale 1ns / 1ps

module brle_queue
	import brle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        run_valid,
	input  logic        run_ready,
	output run_t        run,
	output queue_stat_t stat
);

	run_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 pop;
	logic [QCNT_BITS-1:0] n_push;

	assign run_valid  = (count_q != '0);
	assign run        = mem_q[rptr_q];
	assign pop        = run_valid & run_ready;
	assign n_push     = QCNT_BITS'(push.a_valid) + QCNT_BITS'(push.b_valid);
	assign stat.count = count_q;
	assign stat.room  = (count_q <= QCNT_ROOM);

	always_ff @(posedge clk) begin
		if (push.a_valid) begin
			mem_q[wptr_q] <= push.a;
		end
		if (push.b_valid) begin
			mem_q[wptr_q + QPTR_BITS'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + QPTR_BITS'(n_push);
			rptr_q  <= rptr_q + QPTR_BITS'(pop);
			count_q <= count_q + n_push - QCNT_BITS'(pop);
		end
	end

endmodule
